// ===== hw/rtl/todd_pkg.sv =====
// Shared types, field widths and constants of the triple odometer display.
package todd_pkg;

  // Field widths of the request and result items.
  localparam int unsigned IDX_W     = 2;
  localparam int unsigned SPEED_W   = 8;
  localparam int unsigned LOAD_W    = 40;
  localparam int unsigned KM_W      = 20;
  localparam int unsigned DIV_W     = 24;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned UNITS_W   = 6;
  localparam int unsigned CHAR_POS  = 6;
  localparam int unsigned BCD_W     = 4 * CHAR_POS;

  // Stream packing.
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned IN_TUSER_W  = 1;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned OUT_TUSER_W = IDX_W;

  localparam int unsigned NUM_CNT = 3;
  localparam logic [IDX_W-1:0] IDX_ENGINE = 2'd0;
  localparam logic [IDX_W-1:0] IDX_LAST   = 2'd2;

  localparam logic MODE_LOAD = 1'b1;

  localparam logic [DIV_W-1:0]  DIV_RESET  = 24'd360000;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [3:0]        ASCII_HI   = 4'h3;
  localparam int unsigned       DISP_LIMIT = 999999;

  // Largest displayable value for a given digit count, never above six places.
  function automatic logic [KM_W-1:0] km_cap(input int unsigned digits);
    longint unsigned lim;
    lim = 1;
    for (int unsigned d = 0; d < digits; d++) begin
      lim = lim * 10;
    end
    lim = lim - 1;
    if (lim > DISP_LIMIT) begin
      lim = DISP_LIMIT;
    end
    return KM_W'(lim);
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             acc_add;   // tick request accepted this cycle
    logic             load_wr;   // load request accepted this cycle
    logic             div_init;
    logic             div_step;
    logic             bcd_init;
    logic             bcd_step;
    logic             out_load;
    logic             last;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage

// ===== hw/rtl/todd_ctrl.sv =====
// Sequencer that steps each odometer through division, decimal conversion and output.
module todd_ctrl #(
  parameter int unsigned ACC_WIDTH = 40
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_mode_i,
  output logic              in_ready_o,
  input  todd_pkg::status_t status_i,
  output todd_pkg::cmd_t    cmd_o
);

  localparam int unsigned CntW = $clog2(ACC_WIDTH);
  localparam logic [CntW-1:0] DivLast = CntW'(ACC_WIDTH - 1);
  localparam logic [CntW-1:0] BcdLast = CntW'(todd_pkg::KM_W - 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_START = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_BCDI  = 6'b001000,
    ST_BCD   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  state_e                        state_q, state_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [todd_pkg::IDX_W-1:0]    idx_q, idx_d;
  logic                          accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    cmd_o.idx  = idx_q;
    cmd_o.last = (idx_q == todd_pkg::IDX_LAST);
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_mode_i == todd_pkg::MODE_LOAD) begin
            cmd_o.load_wr = 1'b1;
          end else begin
            cmd_o.acc_add = 1'b1;
            idx_d   = todd_pkg::IDX_ENGINE;
            state_d = ST_START;
          end
        end
      end
      ST_START: begin
        cmd_o.div_init = 1'b1;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DivLast) begin
          state_d = ST_BCDI;
        end
      end
      ST_BCDI: begin
        cmd_o.bcd_init = 1'b1;
        cnt_d   = '0;
        state_d = ST_BCD;
      end
      ST_BCD: begin
        cmd_o.bcd_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == BcdLast) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          if (idx_q == todd_pkg::IDX_LAST) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_START;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      idx_q   <= todd_pkg::IDX_ENGINE;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
    end
  end

endmodule

// ===== hw/rtl/todd_dp.sv =====
// Accumulators, bit-serial divider, double-dabble converter and output register.
module todd_dp #(
  parameter int unsigned                   ACC_WIDTH = 40,
  parameter logic [todd_pkg::KM_W-1:0]     KmCap     = 20'd999999
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  todd_pkg::cmd_t                      cmd_i,
  output todd_pkg::status_t                   status_o,
  input  logic                                cfg_valid_i,
  input  logic [todd_pkg::DIV_W-1:0]          cfg_data_i,
  input  logic                                packet_valid_i,
  input  logic [todd_pkg::SPEED_W-1:0]        speed_kmh_i,
  input  logic [todd_pkg::IDX_W-1:0]          counter_select_i,
  input  logic [todd_pkg::LOAD_W-1:0]         load_value_i,
  output logic                                m_tvalid_o,
  input  logic                                m_tready_i,
  output logic [todd_pkg::OUT_TDATA_W-1:0]    m_tdata_o,
  output logic [todd_pkg::OUT_TUSER_W-1:0]    m_tuser_o,
  output logic                                m_tlast_o
);

  localparam int unsigned DivW = todd_pkg::DIV_W;
  localparam int unsigned KmW  = todd_pkg::KM_W;
  localparam int unsigned BcdW = todd_pkg::BCD_W;
  localparam int unsigned ExtW = (ACC_WIDTH > todd_pkg::LOAD_W) ? ACC_WIDTH : todd_pkg::LOAD_W;
  localparam int unsigned NCnt = todd_pkg::NUM_CNT;

  // Accumulators and divisor register.
  logic [ACC_WIDTH-1:0] acc_q [NCnt];
  logic [DivW-1:0]      div_q;
  logic [ExtW-1:0]      load_ext;
  logic [ExtW-1:0]      acc_max_ext;
  logic [ACC_WIDTH-1:0] load_sat;

  assign load_ext    = ExtW'(load_value_i);
  assign acc_max_ext = ExtW'({ACC_WIDTH{1'b1}});
  assign load_sat    = (load_ext > acc_max_ext) ? ACC_WIDTH'(acc_max_ext) : ACC_WIDTH'(load_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= todd_pkg::DIV_RESET;
    end else if (cfg_valid_i) begin
      div_q <= cfg_data_i;
    end
  end

  for (genvar i = 0; i < NCnt; i++) begin : g_acc
    logic [ACC_WIDTH:0] sum;
    assign sum = {1'b0, acc_q[i]} + (ACC_WIDTH + 1)'(speed_kmh_i);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        acc_q[i] <= '0;
      end else if (cmd_i.acc_add && packet_valid_i) begin
        // A carry out of the top bit pins the accumulator at full scale.
        acc_q[i] <= sum[ACC_WIDTH] ? {ACC_WIDTH{1'b1}} : sum[ACC_WIDTH-1:0];
      end else if (cmd_i.load_wr && (counter_select_i == todd_pkg::IDX_W'(i))) begin
        acc_q[i] <= load_sat;
      end
    end
  end

  // Restoring divider, one quotient bit a cycle. A zero divisor yields all ones,
  // which the saturation below turns into the display maximum.
  logic [DivW-1:0]      rem_q;
  logic [ACC_WIDTH-1:0] quo_q;
  logic [DivW:0]        trial;
  logic                 ge;
  logic [DivW:0]        diff;

  assign trial = {rem_q, quo_q[ACC_WIDTH-1]};
  assign ge    = (trial >= {1'b0, div_q});
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q <= '0;
      quo_q <= acc_q[cmd_i.idx];
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? diff[DivW-1:0] : trial[DivW-1:0];
      quo_q <= {quo_q[ACC_WIDTH-2:0], ge};
    end
  end

  logic [KmW-1:0] km_sat;
  assign km_sat = (quo_q > ACC_WIDTH'(KmCap)) ? KmCap : quo_q[KmW-1:0];

  // Double dabble: add three to every digit of five or more, then shift.
  logic [KmW-1:0]  bin_q;
  logic [BcdW-1:0] bcd_q;
  logic [KmW-1:0]  km_q;
  logic [BcdW-1:0] bcd_adj;

  always_comb begin
    for (int d = 0; d < todd_pkg::CHAR_POS; d++) begin
      bcd_adj[4*d +: 4] = (bcd_q[4*d +: 4] >= 4'd5) ? bcd_q[4*d +: 4] + 4'd3
                                                    : bcd_q[4*d +: 4];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.bcd_init) begin
      bin_q <= km_sat;
      bcd_q <= '0;
      km_q  <= km_sat;
    end else if (cmd_i.bcd_step) begin
      {bcd_q, bin_q} <= {bcd_adj[BcdW-2:0], bin_q, 1'b0};
    end
  end

  // Character formatting; digit 5 is the hundred-thousands place.
  logic [todd_pkg::CHAR_W-1:0] chars [todd_pkg::CHAR_POS];
  logic [todd_pkg::CHAR_POS-1:0] blank;

  always_comb begin
    for (int d = todd_pkg::CHAR_POS - 1; d >= 0; d--) begin
      if (d == todd_pkg::CHAR_POS - 1) begin
        blank[d] = (bcd_q[4*d +: 4] == 4'd0);
      end else begin
        blank[d] = blank[d+1] && (bcd_q[4*d +: 4] == 4'd0);
      end
      chars[d] = (blank[d] && (d != 0)) ? todd_pkg::BLANK_CHAR
                                        : {todd_pkg::ASCII_HI, bcd_q[4*d +: 4]};
    end
  end

  // Output register: holds one result until the downstream side takes it.
  logic                               tvalid_q;
  logic [todd_pkg::OUT_TDATA_W-1:0]   tdata_q;
  logic [todd_pkg::OUT_TUSER_W-1:0]   tuser_q;
  logic                               tlast_q;

  assign status_o.out_busy = tvalid_q && !m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvalid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      tvalid_q <= 1'b1;
    end else if (m_tready_i) begin
      tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      tdata_q <= {6'b0, chars[0][todd_pkg::UNITS_W-1:0], chars[1], chars[2], chars[3],
                  chars[4], chars[5], km_q};
      tuser_q <= cmd_i.idx;
      tlast_q <= cmd_i.last;
    end
  end

  assign m_tvalid_o = tvalid_q;
  assign m_tdata_o  = tdata_q;
  assign m_tuser_o  = tuser_q;
  assign m_tlast_o  = tlast_q;

endmodule

// ===== hw/rtl/triple_odometer_decimal_display.sv =====
// Top level of the triple service odometer with a six-character decimal display.
//
// Three distance accumulators (engine, transmission, brake) each gain the speed
// byte on a tick request that carries a valid packet, saturating at full scale.
// Every tick request then yields three results in order engine, transmission,
// brake, the last marked by tlast; each gives floor(accumulator / km_divisor)
// capped at the display maximum, and that value as six ASCII characters with
// leading zeros blanked. A load request restores one accumulator and yields
// nothing. The divider produces one quotient bit a cycle and the
// binary-to-decimal converter one bit a cycle, shared by the three odometers
// in turn. A new request is taken only once the third result has entered the
// output register. The divisor port is always ready, but the divisor is to be
// written only while no tick is in progress.
module triple_odometer_decimal_display #(
  parameter int unsigned ACC_WIDTH      = 40,
  parameter int unsigned DISPLAY_DIGITS = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // packet_valid, speed_kmh, counter_select, load_value, zero fill
  input  logic [todd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // mode
  input  logic [todd_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // km_value, char_hundred_thousands, char_ten_thousands, char_thousands,
  // char_hundreds, char_tens, char_units, zero fill
  output logic [todd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // counter_index
  output logic [todd_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
  output logic                                m_axis_tlast,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [todd_pkg::DIV_W-1:0]          cfg_data_i
);

  localparam logic [todd_pkg::KM_W-1:0] KmCap = todd_pkg::km_cap(DISPLAY_DIGITS);

  todd_pkg::cmd_t    cmd;
  todd_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  todd_ctrl #(
    .ACC_WIDTH(ACC_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser[0]),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  todd_dp #(
    .ACC_WIDTH(ACC_WIDTH),
    .KmCap    (KmCap)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_data_i       (cfg_data_i),
    .packet_valid_i   (s_axis_tdata[0]),
    .speed_kmh_i      (s_axis_tdata[8:1]),
    .counter_select_i (s_axis_tdata[10:9]),
    .load_value_i     (s_axis_tdata[50:11]),
    .m_tvalid_o       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .m_tdata_o        (m_axis_tdata),
    .m_tuser_o        (m_axis_tuser),
    .m_tlast_o        (m_axis_tlast)
  );

`ifndef ASSERT_OFF
  a_last_on_brake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == todd_pkg::IDX_LAST)))
    else $error("tlast does not match the final odometer");

  a_km_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[19:0] <= KmCap))
    else $error("km_value above the display maximum");

  a_units_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[65:64] == 2'b11 && m_axis_tdata[63:60] <= 4'd9))
    else $error("units character is not an ASCII digit");
`endif

endmodule
